>>> sv/upd_pkg.sv
// Shared types, character codes and hex helpers for the URL percent decoder.
package upd_pkg;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    localparam int unsigned MAX_OUT    = 3;
    localparam int unsigned FIFO_DEPTH = 2;

    // One queued job: up to three decoded bytes, how many are used, end-of-string mark.
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [1:0]              cnt;
        logic                    last;
    } upd_job_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        if (c >= 8'h61)
        begin
            d = c - 8'h57;
        end
        else if (c >= 8'h41)
        begin
            d = c - 8'h37;
        end
        else
        begin
            d = c - 8'h30;
        end
        return d[3:0];
    endfunction

endpackage

>>> sv/upd_front.sv
// Front end: escape state machine that turns input words into jobs of decoded bytes.
module upd_front import upd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       push,
    output upd_job_t   job
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_HIGH = 2'd2
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [7:0]       held_reg, held_next;
    logic [3:0][7:0]  slots;
    logic [1:0]       n;

    always_comb
    begin
        phase_next = PH_IDLE;
        held_next  = held_reg;
        slots      = '0;
        n          = 2'd0;

        case (phase_reg)
            PH_PCT:
            begin
                if (is_hex(in_byte))
                begin
                    held_next  = in_byte;
                    phase_next = PH_HIGH;
                end
                else
                begin
                    slots[n] = PCT_CHAR;
                    n        = n + 2'd1;
                    if (in_byte == PCT_CHAR)
                    begin
                        phase_next = PH_PCT;
                    end
                    else
                    begin
                        slots[n] = (in_byte == PLUS_CHAR) ? SPACE_CHAR : in_byte;
                        n        = n + 2'd1;
                    end
                end
            end
            PH_HIGH:
            begin
                if (is_hex(in_byte))
                begin
                    slots[n] = {hex_val(held_reg), hex_val(in_byte)};
                    n        = n + 2'd1;
                end
                else
                begin
                    slots[n] = PCT_CHAR;
                    n        = n + 2'd1;
                    slots[n] = held_reg;
                    n        = n + 2'd1;
                    if (in_byte == PCT_CHAR)
                    begin
                        phase_next = PH_PCT;
                    end
                    else
                    begin
                        slots[n] = (in_byte == PLUS_CHAR) ? SPACE_CHAR : in_byte;
                        n        = n + 2'd1;
                    end
                end
            end
            default:
            begin
                if (in_byte == PCT_CHAR)
                begin
                    phase_next = PH_PCT;
                end
                else
                begin
                    slots[n] = (in_byte == PLUS_CHAR) ? SPACE_CHAR : in_byte;
                    n        = n + 2'd1;
                end
            end
        endcase

        // end of string: flush whatever is still held
        if (in_last)
        begin
            if (phase_next == PH_PCT)
            begin
                slots[n] = PCT_CHAR;
                n        = n + 2'd1;
            end
            else if (phase_next == PH_HIGH)
            begin
                slots[n] = PCT_CHAR;
                n        = n + 2'd1;
                slots[n] = held_next;
                n        = n + 2'd1;
            end
            phase_next = PH_IDLE;
            held_next  = 8'h00;
        end

        job.bytes = slots[MAX_OUT-1:0];
        job.cnt   = n;
        job.last  = in_last;
    end

    assign push = in_valid && in_ready && (n != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'h00;
        end
        else if (in_valid && in_ready)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

>>> sv/upd_fifo.sv
// Two-entry job queue between the front end and the output serializer.
module upd_fifo import upd_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  upd_job_t wr_job,
    output logic     not_full,
    input  logic     pop,
    output logic     not_empty,
    output upd_job_t rd_job
);

    localparam int unsigned PW = $clog2(FIFO_DEPTH);
    localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

    upd_job_t        mem [FIFO_DEPTH];
    logic [PW-1:0]   wptr_reg, rptr_reg;
    logic [CW-1:0]   count_reg;

    assign not_full  = (count_reg != CW'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_job    = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            count_reg <= count_reg + CW'(push) - CW'(pop);
        end
    end

endmodule

>>> sv/upd_back.sv
// Back end: walks the bytes of each queued job into the output register.
module upd_back import upd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  upd_job_t   head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       load;
    logic       final_byte;

    assign load       = head_valid && (!valid_reg || out_ready);
    assign final_byte = (idx_reg == head.cnt - 2'd1);
    assign pop        = load && final_byte;

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head.bytes[idx_reg];
            last_reg <= final_byte && head.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg   <= final_byte ? 2'd0 : idx_reg + 2'd1;
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 2'd3)
        else $error("byte index out of range");

    a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 2'd0 |-> head_valid)
        else $error("job left the queue before all bytes were sent");

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 2'd0 |-> idx_reg < head.cnt)
        else $error("byte index beyond job length");

    a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
        load && head.last && final_byte |=> out_last)
        else $error("end-of-string mark lost");

endmodule

>>> sv/url_percent_decoder.sv
// Top level of the streaming URL percent decoder.
// Decodes one encoded character per word: "%hh" (either case) becomes one byte, '+' becomes
// a space, and a '%' not followed by two hex digits passes through literally, with the bytes
// after it decoded again. s_tlast marks the last character of a string; held escape bytes are
// then flushed and the last decoded word carries m_tlast. One input word is taken per cycle while
// the job queue has room, and one output word leaves per cycle while a job is queued and
// m_tready is high; a word that expands into two or three output bytes (failed escape,
// end-of-string flush) holds the input side once the two-entry job queue fills.
module url_percent_decoder import upd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // out_last
);

    upd_job_t wr_job, rd_job;
    logic     push, pop, not_full, not_empty;

    assign s_tready = not_full;

    upd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (not_full),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .push     (push),
        .job      (wr_job)
    );

    upd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_job    (wr_job),
        .not_full  (not_full),
        .pop       (pop),
        .not_empty (not_empty),
        .rd_job    (rd_job)
    );

    upd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (not_empty),
        .head       (rd_job),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

>>> dv/url_percent_decoder_tb.sv
// Self-checking testbench for the streaming URL percent decoder.
module url_percent_decoder_tb;
    import upd_pkg::*;

    localparam int LIMIT_CYCLES = 100000;
    localparam int HOLD_CYCLES  = 64;

    typedef enum logic [1:0] {ESC_IDLE, ESC_PCT, ESC_HIGH} esc_phase_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } enc_char_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } dec_char_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;    // [7:0] in_byte
    logic       s_tlast = 1'b0;     // in_last
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic       m_tlast;            // out_last

    enc_char_t  enc_q[$];
    dec_char_t  decoded_q[$];

    esc_phase_t esc_phase = ESC_IDLE;
    logic [7:0] held_digit = 8'h00;

    int n_items;
    int n_strings;
    int n_accepted;
    int n_words;
    int n_errors;
    int n_cycles;
    int stage;
    int hold_left;
    bit held_off;

    url_percent_decoder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic bit is_hex_digit(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_nibble(logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h61)
        begin
            v = c - 8'h61 + 8'd10;
        end
        else if (c >= 8'h41)
        begin
            v = c - 8'h41 + 8'd10;
        end
        else
        begin
            v = c - 8'h30;
        end
        return v[3:0];
    endfunction

    // a character seen from idle: '%' opens an escape, '+' is a space
    function automatic void decode_plain(logic [7:0] c, ref logic [7:0] outs[$]);
        if (c == PCT_CHAR)
        begin
            esc_phase = ESC_PCT;
        end
        else if (c == PLUS_CHAR)
        begin
            outs.push_back(SPACE_CHAR);
        end
        else
        begin
            outs.push_back(c);
        end
    endfunction

    function automatic void decode_char(logic [7:0] c, logic last);
        logic [7:0] outs[$];
        case (esc_phase)
            ESC_PCT:
            begin
                if (is_hex_digit(c))
                begin
                    held_digit = c;
                    esc_phase  = ESC_HIGH;
                end
                else
                begin
                    esc_phase = ESC_IDLE;
                    outs.push_back(PCT_CHAR);
                    decode_plain(c, outs);
                end
            end
            ESC_HIGH:
            begin
                esc_phase = ESC_IDLE;
                if (is_hex_digit(c))
                begin
                    outs.push_back({hex_nibble(held_digit), hex_nibble(c)});
                end
                else
                begin
                    outs.push_back(PCT_CHAR);
                    outs.push_back(held_digit);
                    decode_plain(c, outs);
                end
            end
            default:
            begin
                esc_phase = ESC_IDLE;
                decode_plain(c, outs);
            end
        endcase
        if (last)
        begin
            if (esc_phase == ESC_PCT)
            begin
                outs.push_back(PCT_CHAR);
            end
            else if (esc_phase == ESC_HIGH)
            begin
                outs.push_back(PCT_CHAR);
                outs.push_back(held_digit);
            end
            esc_phase  = ESC_IDLE;
            held_digit = 8'h00;
        end
        foreach (outs[i])
        begin
            decoded_q.push_back('{ch: outs[i], last: last && (i == outs.size() - 1)});
        end
    endfunction

    function automatic void add_char(logic [7:0] c, logic last);
        enc_q.push_back('{ch: c, last: last});
    endfunction

    function automatic void add_str(string s, logic last);
        for (int i = 0; i < s.len(); i++)
        begin
            add_char(s[i], last && (i == s.len() - 1));
        end
    endfunction

    function automatic logic [7:0] rand_hex();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10)
        begin
            return 8'(8'h30 + v);
        end
        else if (v < 16)
        begin
            return 8'(8'h61 + v - 10);
        end
        return 8'(8'h41 + v - 16);
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(1, 255));
        end
        while (is_hex_digit(c));
        return c;
    endfunction

    // random string of mixed tokens, last flag on its final character
    function automatic void add_random_string();
        int         n_tok;
        int         kind;
        logic [7:0] chars[$];
        n_tok = $urandom_range(1, 8);
        for (int t = 0; t < n_tok; t++)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 3)
            begin
                chars.push_back(8'($urandom_range(1, 255)));
            end
            else if (kind == 4)
            begin
                chars.push_back(PLUS_CHAR);
            end
            else if (kind <= 7)
            begin
                chars.push_back(PCT_CHAR);
                chars.push_back(rand_hex());
                chars.push_back(rand_hex());
            end
            else if (kind == 8)
            begin
                chars.push_back(PCT_CHAR);
                if ($urandom_range(0, 1))
                begin
                    chars.push_back(rand_hex());
                end
                chars.push_back(rand_non_hex());
            end
            else
            begin
                chars.push_back(PCT_CHAR);
            end
        end
        foreach (chars[i])
        begin
            add_char(chars[i], i == chars.size() - 1);
        end
    endfunction

    function automatic int send_idle_pct(int stg);
        return (stg == 0) ? 22 : (stg == 1) ? 78 : 0;
    endfunction

    function automatic int recv_idle_pct(int stg);
        return (stg == 0) ? 78 : (stg == 1) ? 22 : 0;
    endfunction

    // driver
    always @(posedge clk)
    begin
        enc_char_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                decode_char(s_tdata, s_tlast);
                n_accepted++;
            end
            stage <= (n_accepted < n_items / 3) ? 0 : (n_accepted < 2 * n_items / 3) ? 1 : 2;
            if (!s_tvalid || s_tready)
            begin
                if (enc_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct(stage))
                begin
                    nxt = enc_q.pop_front();
                    s_tdata  <= nxt.ch;
                    s_tlast  <= nxt.last;
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge clk)
    begin
        dec_char_t exp_w;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                n_words++;
                if (decoded_q.size() == 0)
                begin
                    $error("unexpected word: out_byte 0x%02h out_last %0b", m_tdata, m_tlast);
                    n_errors++;
                end
                else
                begin
                    exp_w = decoded_q.pop_front();
                    if (m_tdata !== exp_w.ch)
                    begin
                        $error("out_byte: expected 0x%02h, got 0x%02h", exp_w.ch, m_tdata);
                        n_errors++;
                    end
                    if (m_tlast !== exp_w.last)
                    begin
                        $error("out_last: expected %0b, got %0b", exp_w.last, m_tlast);
                        n_errors++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!held_off && n_words >= 30)
            begin
                // long back-pressure so the input side fills and stalls
                held_off  = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct(stage));
            end
        end
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles == LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     n_cycles, decoded_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        // directed strings
        add_char(8'h61, 1'b0);
        add_char(PLUS_CHAR, 1'b0);
        add_char(8'hFF, 1'b0);
        add_char(8'h01, 1'b1);
        add_str("%4f%C0%00%g%4z", 1'b0);
        add_str("%4+", 1'b1);
        add_str("%%", 1'b1);
        add_str("%", 1'b1);
        add_str("%A", 1'b1);
        while (enc_q.size() < 230)
        begin
            add_random_string();
        end
        n_items = enc_q.size();
        foreach (enc_q[i])
        begin
            n_strings += enc_q[i].last;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (!(n_accepted == n_items && decoded_q.size() == 0))
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        $display("Fed %0d encoded characters in %0d strings across three stall profiles",
                 n_items, n_strings);
        $display("and one long output hold; %0d decoded words checked, %0d errors.",
                 n_words, n_errors);
        if (n_errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/upd_pkg.sv
sv/upd_front.sv
sv/upd_fifo.sv
sv/upd_back.sv
sv/url_percent_decoder.sv
dv/url_percent_decoder_tb.sv
